// ----- rtl/abas_pkg.sv -----
package abas_pkg;

	// Field widths.
	localparam int CH_W    = 3;
	localparam int SMP_W   = 12;
	localparam int SUM_W   = 27;
	localparam int CNT_W   = 15;
	localparam int VOLT_W  = 9;
	localparam int MASK_W  = 8;

	// Configuration port.
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 15;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MASK   = 2'd1;

	localparam int NUM_CHANNELS_DEF = 8;
	localparam int QUEUE_DEPTH      = 2;

	// Voltage scaling: volts = avg * VOLT_GAIN / VOLT_DIV.
	localparam int VOLT_GAIN   = 330;
	localparam int VOLT_DIV    = 4094;
	localparam int GAIN_W      = 9;
	localparam int PROD_W      = SMP_W + GAIN_W;
	localparam int RECIP_SHIFT = 32;
	localparam logic [PROD_W-1:0] RECIP_MUL =
		PROD_W'((64'd1 << RECIP_SHIFT) / VOLT_DIV);

	// Item classes decided by the front end.
	localparam int OP_W = 2;
	localparam logic [OP_W-1:0] OP_IGNORE = 2'd0;  // channel not implemented
	localparam logic [OP_W-1:0] OP_HOLD   = 2'd1;  // channel disabled
	localparam logic [OP_W-1:0] OP_UPDATE = 2'd2;  // channel enabled

	typedef struct packed {
		logic [OP_W-1:0]  op;
		logic [CH_W-1:0]  channel;
		logic [SMP_W-1:0] sample;
	} item_t;

endpackage

// ----- rtl/abas_front.sv -----
module abas_front #(
	parameter int NUM_CHANNELS = abas_pkg::NUM_CHANNELS_DEF
) (
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [abas_pkg::CH_W-1:0]   channel,
	input  logic [abas_pkg::SMP_W-1:0]  sample_value,
	input  logic [abas_pkg::MASK_W-1:0] enable_mask,
	output logic                        push_valid,
	input  logic                        push_ready,
	output abas_pkg::item_t             push_item
);

	logic in_range;

	// A channel number past the implemented ones is ignored outright.
	assign in_range = {1'b0, channel} < (abas_pkg::CH_W + 1)'(NUM_CHANNELS);

	always_comb begin
		push_item.channel = channel;
		push_item.sample  = sample_value;
		if (!in_range) begin
			push_item.op = abas_pkg::OP_IGNORE;
		end else if (enable_mask[channel]) begin
			push_item.op = abas_pkg::OP_UPDATE;
		end else begin
			push_item.op = abas_pkg::OP_HOLD;
		end
	end

	assign push_valid = in_valid;
	assign in_ready   = push_ready;

endmodule

// ----- rtl/abas_queue.sv -----
module abas_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  abas_pkg::item_t push_item,
	output logic            pop_valid,
	input  logic            pop_ready,
	output abas_pkg::item_t pop_item
);

	localparam int PTR_W = (abas_pkg::QUEUE_DEPTH > 1) ? $clog2(abas_pkg::QUEUE_DEPTH) : 1;

	abas_pkg::item_t    entry_q [abas_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [PTR_W:0]     fill_q;
	logic               do_push;
	logic               do_pop;

	assign push_ready = fill_q != (PTR_W + 1)'(abas_pkg::QUEUE_DEPTH);
	assign pop_valid  = fill_q != '0;
	assign pop_item   = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(abas_pkg::QUEUE_DEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(abas_pkg::QUEUE_DEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

// ----- rtl/abas_div.sv -----
module abas_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [abas_pkg::SUM_W-1:0]  dividend,
	input  logic [abas_pkg::CNT_W-1:0]  divisor,
	output logic                        done,
	output logic [abas_pkg::SUM_W-1:0]  quotient
);

	localparam int STEP_W = $clog2(abas_pkg::SUM_W);

	logic [abas_pkg::SUM_W-1:0] quo_q;
	logic [abas_pkg::CNT_W-1:0] rem_q;
	logic [abas_pkg::CNT_W-1:0] dvs_q;
	logic [STEP_W-1:0]          step_q;
	logic                       busy_q;
	logic                       done_q;
	logic [abas_pkg::CNT_W:0]   trial;
	logic [abas_pkg::CNT_W:0]   diff;
	logic                       fits;

	// Restoring division, one quotient bit per cycle. The dividend shifts out
	// of the top of quo_q while quotient bits shift in at the bottom.
	assign trial = {rem_q, quo_q[abas_pkg::SUM_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(abas_pkg::SUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[abas_pkg::SUM_W-2:0], fits};
			rem_q <= fits ? diff[abas_pkg::CNT_W-1:0] : trial[abas_pkg::CNT_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ----- rtl/abas_back.sv -----
module abas_back #(
	parameter int NUM_CHANNELS = abas_pkg::NUM_CHANNELS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [abas_pkg::CNT_W-1:0]  window,
	input  logic                        pop_valid,
	output logic                        pop_ready,
	input  abas_pkg::item_t             pop_item,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [abas_pkg::CH_W-1:0]   out_channel,
	output logic                        channel_active,
	output logic                        average_updated,
	output logic [abas_pkg::SMP_W-1:0]  latest_raw,
	output logic [abas_pkg::SMP_W-1:0]  averaged_raw,
	output logic [abas_pkg::VOLT_W-1:0] scaled_voltage
);

	localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_EVAL  = 3'd1;
	localparam logic [2:0] ST_DIV   = 3'd2;
	localparam logic [2:0] ST_SCALE = 3'd3;
	localparam logic [2:0] ST_RECIP = 3'd4;
	localparam logic [2:0] ST_FIX   = 3'd5;
	localparam logic [2:0] ST_OUT   = 3'd6;

	logic [2:0] state_q;

	// Per-channel state.
	logic [abas_pkg::SUM_W-1:0]  sum_q   [NUM_CHANNELS];
	logic [abas_pkg::CNT_W-1:0]  cnt_q   [NUM_CHANNELS];
	logic [abas_pkg::SMP_W-1:0]  smp_q   [NUM_CHANNELS];
	logic [abas_pkg::SMP_W-1:0]  avg_q   [NUM_CHANNELS];
	logic [abas_pkg::VOLT_W-1:0] volt_q  [NUM_CHANNELS];

	abas_pkg::item_t             item_q;
	logic                        updated_q;
	logic [abas_pkg::SMP_W-1:0]  quo_sat_q;
	logic [abas_pkg::PROD_W-1:0] prod_q;
	logic [abas_pkg::VOLT_W-1:0] est_q;
	logic                        out_valid_q;
	logic [abas_pkg::CH_W-1:0]   out_ch_q;
	logic                        out_act_q;
	logic                        out_upd_q;
	logic [abas_pkg::SMP_W-1:0]  out_lat_q;
	logic [abas_pkg::SMP_W-1:0]  out_avg_q;
	logic [abas_pkg::VOLT_W-1:0] out_volt_q;

	logic [IDX_W-1:0]            idx;
	logic                        is_update;
	logic                        close_win;
	logic                        div_done;
	logic [abas_pkg::SUM_W-1:0]  div_quo;
	logic [abas_pkg::SMP_W-1:0]  quo_sat;
	logic [2*abas_pkg::PROD_W-1:0] recip_full;
	logic [abas_pkg::PROD_W-1:0] est_back;
	logic [abas_pkg::PROD_W-1:0] est_rem;
	logic [abas_pkg::VOLT_W-1:0] volt_fix;
	logic                        out_load;

	assign idx       = item_q.channel[IDX_W-1:0];
	assign is_update = item_q.op == abas_pkg::OP_UPDATE;
	assign close_win = (state_q == ST_EVAL) && is_update && (cnt_q[idx] >= window);
	assign pop_ready = state_q == ST_IDLE;
	assign out_load  = (state_q == ST_OUT) && (!out_valid_q || out_ready);

	abas_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (close_win),
		.dividend (sum_q[idx]),
		.divisor  (window),
		.done     (div_done),
		.quotient (div_quo)
	);

	// The quotient saturates to the sample range when the window shrank.
	assign quo_sat = (|div_quo[abas_pkg::SUM_W-1:abas_pkg::SMP_W]) ?
		'1 : div_quo[abas_pkg::SMP_W-1:0];

	// Division by the voltage divisor: a reciprocal estimate that is exact
	// or one low, then one correcting compare.
	assign recip_full = {{abas_pkg::PROD_W{1'b0}}, prod_q} *
		{{abas_pkg::PROD_W{1'b0}}, abas_pkg::RECIP_MUL};
	assign est_back = abas_pkg::PROD_W'(est_q) * abas_pkg::PROD_W'(abas_pkg::VOLT_DIV);
	assign est_rem  = prod_q - est_back;
	assign volt_fix = (est_rem >= abas_pkg::PROD_W'(abas_pkg::VOLT_DIV)) ?
		est_q + 1'b1 : est_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				sum_q[i]  <= '0;
				cnt_q[i]  <= '0;
				smp_q[i]  <= '0;
				avg_q[i]  <= '0;
				volt_q[i] <= '0;
			end
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (pop_valid) begin
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					if (close_win) begin
						state_q <= ST_DIV;
					end else begin
						if (is_update) begin
							sum_q[idx] <= sum_q[idx] +
								abas_pkg::SUM_W'(item_q.sample);
							cnt_q[idx] <= cnt_q[idx] + 1'b1;
							smp_q[idx] <= item_q.sample;
						end
						state_q <= ST_OUT;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_SCALE;
					end
				end
				ST_SCALE: begin
					state_q <= ST_RECIP;
				end
				ST_RECIP: begin
					state_q <= ST_FIX;
				end
				ST_FIX: begin
					avg_q[idx]  <= quo_sat_q;
					volt_q[idx] <= volt_fix;
					sum_q[idx]  <= '0;
					cnt_q[idx]  <= '0;
					state_q     <= ST_OUT;
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop_valid && pop_ready) begin
			item_q <= pop_item;
		end
		if (state_q == ST_EVAL) begin
			updated_q <= close_win;
		end
		if (div_done) begin
			quo_sat_q <= quo_sat;
		end
		if (state_q == ST_SCALE) begin
			prod_q <= abas_pkg::PROD_W'(quo_sat_q) *
				abas_pkg::PROD_W'(abas_pkg::VOLT_GAIN);
		end
		if (state_q == ST_RECIP) begin
			est_q <= recip_full[abas_pkg::RECIP_SHIFT +: abas_pkg::VOLT_W];
		end
		if (out_load) begin
			out_ch_q  <= item_q.channel;
			out_act_q <= is_update;
			out_upd_q <= updated_q;
			if (item_q.op == abas_pkg::OP_IGNORE) begin
				out_lat_q  <= '0;
				out_avg_q  <= '0;
				out_volt_q <= '0;
			end else begin
				out_lat_q  <= smp_q[idx];
				out_avg_q  <= avg_q[idx];
				out_volt_q <= volt_q[idx];
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign out_channel     = out_ch_q;
	assign channel_active  = out_act_q;
	assign average_updated = out_upd_q;
	assign latest_raw      = out_lat_q;
	assign averaged_raw    = out_avg_q;
	assign scaled_voltage  = out_volt_q;

`ifndef SYNTHESIS
	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV))
		else $error("divider finished outside of the divide state");

	a_div_only_update: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (item_q.op == abas_pkg::OP_UPDATE))
		else $error("window closed for a channel that is not enabled");

	a_est_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIX) |-> (volt_fix <= abas_pkg::VOLT_W'(abas_pkg::VOLT_GAIN)))
		else $error("scaled voltage out of range");

	a_pop_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |=> ($stable(item_q) || ($past(state_q) == ST_IDLE)))
		else $error("working item changed in mid flight");
`endif

endmodule

// ----- rtl/adc_block_average_scaler_top.sv -----
// ADC block averaging decimator with fixed voltage scaling.
// Input channel: in_valid/in_ready carry one converter sample (sample_value)
// tagged with its channel number. Every request yields exactly one result on
// out_valid/out_ready: the channel, whether it was enabled, whether this
// sample closed a window, and the channel's latest sample, last average and
// scaled voltage in hundredths of a volt.
// Configuration channel: cfg_valid/cfg_ready with cfg_index and cfg_data.
// Index 0 sets window_length (15 bits, zero acts as one), index 1 sets
// channel_enable_mask (8 bits); other indexes are ignored. cfg_ready is
// always high. Write only while no request is in flight.
// A sample that accumulates or is ignored passes through the evaluate and
// output states; the execution unit takes the next request only after the
// current result has entered the output register. A sample that closes a
// window also runs the 27-bit restoring divider, which produces one quotient
// bit per cycle, followed by three scaling steps.
// A two-entry queue sits between the front end and the execution unit, so
// up to two further requests are accepted while one is executing; a stalled
// receiver holds the result register and backs the queue up.
// Reset clears all per-channel state, sets the window to 1 and disables
// every channel.
module adc_block_average_scaler_top #(
	parameter int NUM_CHANNELS = abas_pkg::NUM_CHANNELS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [abas_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [abas_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [abas_pkg::CH_W-1:0]       channel,
	input  logic [abas_pkg::SMP_W-1:0]      sample_value,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [abas_pkg::CH_W-1:0]       out_channel,
	output logic                            channel_active,
	output logic                            average_updated,
	output logic [abas_pkg::SMP_W-1:0]      latest_raw,
	output logic [abas_pkg::SMP_W-1:0]      averaged_raw,
	output logic [abas_pkg::VOLT_W-1:0]     scaled_voltage
);

	// Configuration registers.
	logic [abas_pkg::CNT_W-1:0]  window_q;
	logic [abas_pkg::MASK_W-1:0] mask_q;
	logic [abas_pkg::CNT_W-1:0]  window_eff;

	logic            push_valid;
	logic            push_ready;
	abas_pkg::item_t push_item;
	logic            pop_valid;
	logic            pop_ready;
	abas_pkg::item_t pop_item;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= abas_pkg::CNT_W'(1);
			mask_q   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				abas_pkg::REG_WINDOW: begin
					window_q <= cfg_data[abas_pkg::CNT_W-1:0];
				end
				abas_pkg::REG_MASK: begin
					mask_q <= cfg_data[abas_pkg::MASK_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// A zero window behaves exactly like a window of one.
	assign window_eff = (window_q == '0) ? abas_pkg::CNT_W'(1) : window_q;

	// The front end classifies each request by channel and enable bit.
	abas_front #(
		.NUM_CHANNELS (NUM_CHANNELS)
	) u_front (
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.channel      (channel),
		.sample_value (sample_value),
		.enable_mask  (mask_q),
		.push_valid   (push_valid),
		.push_ready   (push_ready),
		.push_item    (push_item)
	);

	abas_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_item   (pop_item)
	);

	// The back end owns the per-channel state, the divider and the scaler.
	abas_back #(
		.NUM_CHANNELS (NUM_CHANNELS)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.window          (window_eff),
		.pop_valid       (pop_valid),
		.pop_ready       (pop_ready),
		.pop_item        (pop_item),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.out_channel     (out_channel),
		.channel_active  (channel_active),
		.average_updated (average_updated),
		.latest_raw      (latest_raw),
		.averaged_raw    (averaged_raw),
		.scaled_voltage  (scaled_voltage)
	);

endmodule
